/* rtl/core/assert_macros.svh */
// Assertion macros used by the polyline projection datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPP_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define PPP_ASSERT_NR(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);
`else
`define PPP_ASSERT(lbl, ck, rn, prop, msg)
`define PPP_ASSERT_NR(lbl, ck, prop, msg)
`endif
`endif

/* rtl/core/ppp_pkg.sv */
// Types, widths and helper functions for the polyline projection block
package ppp_pkg;
	localparam int COORD_W = 32;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAG_W = COORD_W + 1;
	localparam int PROD_W = 2 * MAG_W;
	localparam int RAD_W = PROD_W;
	localparam int ROOT_W = RAD_W / 2;
	localparam int DIST_W = ROOT_W + 1;
	localparam int DOT_W = PROD_W + 1;
	localparam int LEN_W = PROD_W;
	localparam int NUM_W = DOT_W + MAG_W + 2;
	localparam int Q_W = 51;
	localparam int SUM_W = Q_W + 2;
	localparam int SEG_W = 6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;
	localparam logic [1:0] ST_OVF = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_LOAD, OP_QSET, OP_READ, OP_DIFF, OP_SQX, OP_SQY,
		OP_SUMS, OP_SQ_START, OP_SCORE, OP_PSEL, OP_PV1, OP_EDGE, OP_ZERO,
		OP_MDOTX, OP_MDOTY, OP_DOTSUM, OP_LENX, OP_LENY, OP_LENSUM,
		OP_NUM0, OP_NUM1, OP_NUM2, OP_NUM3, OP_DIV_START, OP_AXIS, OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECIDE, S_RD, S_DIFF, S_SQX, S_SQY, S_SUMS, S_SQ_START, S_SQ_WAIT,
		S_SCORE, S_PSEL, S_PRD1, S_PV1, S_PRD2, S_EDGE, S_ZCHK,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_A1, S_A2, S_A3, S_A4,
		S_DV_START, S_DV_WAIT, S_AFIN, S_OUT
	} ppp_state_t;

	typedef struct packed {
		dp_op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_query;
		logic overflowed;
		logic short_line;
		logic last_vertex;
		logic zero_seg;
		logic sqrt_done;
		logic div_done;
		logic axis_y;
		logic out_free;
	} dp_stat_t;

	function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
		return v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end
		return v[COORD_W-1:0];
	endfunction
endpackage

/* rtl/core/ppp_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle
module ppp_sqrt import ppp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root,
	output logic              done
);
	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W+1:0]  rs;
	logic [REM_W+1:0]  trial;
	logic              ge;

	assign rs = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial = (REM_W+2)'({root_q, 2'b01});
	assign ge = rs >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q <= ge ? REM_W'(rs - trial) : rs[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

/* rtl/core/ppp_div.sv */
// Restoring divider, one quotient bit per cycle
module ppp_div import ppp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [LEN_W-1:0] den,
	output logic [NUM_W-1:0] quot,
	output logic             done
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] nq_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   rs;
	logic             ge;

	assign rs = {rem_q, nq_q[NUM_W-1]};
	assign ge = rs >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? LEN_W'(rs - {1'b0, den_q}) : rs[LEN_W-1:0];
			nq_q <= {nq_q[NUM_W-2:0], ge};
		end
	end

	assign quot = nq_q;
	assign done = done_q;
endmodule

/* rtl/core/ppp_dp.sv */
// Datapath: vertex store, shared multiplier, distance scan and projection
`include "assert_macros.svh"
module ppp_dp import ppp_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output dp_stat_t            stat,
	input  logic                req_type,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [COORD_W-1:0] proj_x,
	output logic signed [COORD_W-1:0] proj_y,
	output logic [SEG_W-1:0]    segment_index,
	output logic [1:0]          status
);
	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNTW = $clog2(MAX_VERTICES + 1);

	logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
	logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];

	logic [CNTW-1:0] vcount_q;
	logic            line_closed_q;
	logic            overflowed_q;
	logic            out_valid_q;

	logic                      is_query_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic signed [COORD_W-1:0] rd_x_q, rd_y_q;
	logic signed [COORD_W-1:0] x1_q, y1_q;
	logic [AW-1:0]             idx_q, best_q;
	logic [ROOT_W-1:0]         dprev_q;
	logic [DIST_W-1:0]         bestd_q;
	logic [MAG_W-1:0]          mdx_q, mdy_q;
	logic [MAG_W-1:0]          emx_q, emy_q, mqx_q, mqy_q;
	logic                      ex_neg_q, ey_neg_q, qx_neg_q, qy_neg_q;
	logic [PROD_W-1:0]         prod_q;
	logic [NUM_W-1:0]          acc_q;
	logic [DOT_W-1:0]          dot_mag_q;
	logic                      dot_neg_q;
	logic [LEN_W-1:0]          len2_q;
	logic                      axis_q;
	logic signed [COORD_W-1:0] res_x_q, res_y_q;
	logic [SEG_W-1:0]          res_seg_q;
	logic [1:0]                res_status_q;
	logic signed [COORD_W-1:0] proj_x_q, proj_y_q;
	logic [SEG_W-1:0]          seg_q;
	logic [1:0]                status_q;

	logic [CNTW-1:0]   eff_cnt;
	logic              mem_full;
	logic [AW-1:0]     wr_addr;
	logic signed [MAG_W-1:0] dx_s, dy_s, ex_s, ey_s, qx_s, qy_s;
	logic [MAG_W-1:0]  mul_a, mul_b, em;
	logic [PROD_W-1:0] mul_p;
	logic [NUM_W-1:0]  prod_ext, prod_sgn_x, prod_sgn_y;
	logic [DIST_W-1:0] dsum;
	logic [ROOT_W-1:0] sq_root;
	logic              sq_done;
	logic [NUM_W-1:0]  quot;
	logic              dv_done;
	logic [Q_W-1:0]    qm;
	logic signed [COORD_W-1:0] v1;
	logic              off_neg;
	logic signed [SUM_W-1:0] r_sum;
	logic [COORD_W-1:0] r_sat;

	assign eff_cnt = line_closed_q ? '0 : vcount_q;
	assign mem_full = eff_cnt == CNTW'(MAX_VERTICES);
	assign wr_addr = eff_cnt[AW-1:0];

	assign dx_s = MAG_W'(rd_x_q) - MAG_W'(px_q);
	assign dy_s = MAG_W'(rd_y_q) - MAG_W'(py_q);
	assign ex_s = MAG_W'(rd_x_q) - MAG_W'(x1_q);
	assign ey_s = MAG_W'(rd_y_q) - MAG_W'(y1_q);
	assign qx_s = MAG_W'(px_q) - MAG_W'(x1_q);
	assign qy_s = MAG_W'(py_q) - MAG_W'(y1_q);

	assign em = axis_q ? emy_q : emx_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQX: begin mul_a = mdx_q; mul_b = mdx_q; end
			OP_SQY: begin mul_a = mdy_q; mul_b = mdy_q; end
			OP_MDOTX: begin mul_a = emx_q; mul_b = mqx_q; end
			OP_MDOTY: begin mul_a = emy_q; mul_b = mqy_q; end
			OP_LENX: begin mul_a = emx_q; mul_b = emx_q; end
			OP_LENY: begin mul_a = emy_q; mul_b = emy_q; end
			OP_NUM0: begin mul_a = dot_mag_q[MAG_W-1:0]; mul_b = em; end
			OP_NUM1: begin mul_a = dot_mag_q[2*MAG_W-1:MAG_W]; mul_b = em; end
			OP_NUM2: begin mul_a = MAG_W'(dot_mag_q[DOT_W-1]); mul_b = em; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign prod_ext = NUM_W'(prod_q);
	assign prod_sgn_x = (ex_neg_q ^ qx_neg_q) ? NUM_W'(0) - prod_ext : prod_ext;
	assign prod_sgn_y = (ey_neg_q ^ qy_neg_q) ? NUM_W'(0) - prod_ext : prod_ext;
	assign dsum = DIST_W'(dprev_q) + DIST_W'(sq_root);

	assign qm = (quot > NUM_W'(1) << (Q_W - 1)) ? Q_W'(1) << (Q_W - 1) : quot[Q_W-1:0];
	assign v1 = axis_q ? y1_q : x1_q;
	assign off_neg = dot_neg_q ^ (axis_q ? ey_neg_q : ex_neg_q);
	assign r_sum = off_neg ? SUM_W'(v1) - SUM_W'(qm) : SUM_W'(v1) + SUM_W'(qm);
	assign r_sat = sat_coord(r_sum);

	ppp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQ_START),
		.radicand (acc_q[RAD_W-1:0]),
		.root     (sq_root),
		.done     (sq_done)
	);

	ppp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV_START),
		.num    (acc_q),
		.den    (len2_q),
		.quot   (quot),
		.done   (dv_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD && !mem_full) begin
			mem_x[wr_addr] <= px_q;
			mem_y[wr_addr] <= py_q;
		end
		if (cmd.op == OP_READ) begin
			rd_x_q <= mem_x[idx_q];
			rd_y_q <= mem_y[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			line_closed_q <= 1'b0;
			overflowed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD) begin
				overflowed_q <= mem_full | (overflowed_q & ~line_closed_q);
				vcount_q <= mem_full ? eff_cnt : eff_cnt + 1'b1;
				line_closed_q <= 1'b0;
			end else if (cmd.op == OP_QSET) begin
				line_closed_q <= 1'b1;
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (cmd.op)
			OP_CAPTURE: begin
				is_query_q <= req_type;
				px_q <= coord_x;
				py_q <= coord_y;
			end
			OP_QSET: begin
				idx_q <= '0;
				axis_q <= 1'b0;
				res_x_q <= '0;
				res_y_q <= '0;
				res_seg_q <= '0;
				res_status_q <= overflowed_q ? ST_OVF :
					(vcount_q < CNTW'(2)) ? ST_SHORT : ST_OK;
			end
			OP_DIFF: begin
				mdx_q <= mag(dx_s);
				mdy_q <= mag(dy_s);
			end
			OP_SQY: acc_q <= prod_ext;
			OP_SUMS: acc_q <= acc_q + prod_ext;
			OP_SCORE: begin
				if (idx_q != '0 && (idx_q == AW'(1) || dsum < bestd_q)) begin
					bestd_q <= dsum;
					best_q <= idx_q - 1'b1;
				end
				dprev_q <= sq_root;
				idx_q <= idx_q + 1'b1;
			end
			OP_PSEL: idx_q <= best_q;
			OP_PV1: begin
				x1_q <= rd_x_q;
				y1_q <= rd_y_q;
				idx_q <= best_q + 1'b1;
			end
			OP_EDGE: begin
				emx_q <= mag(ex_s);
				emy_q <= mag(ey_s);
				ex_neg_q <= ex_s[MAG_W-1];
				ey_neg_q <= ey_s[MAG_W-1];
				mqx_q <= mag(qx_s);
				mqy_q <= mag(qy_s);
				qx_neg_q <= qx_s[MAG_W-1];
				qy_neg_q <= qy_s[MAG_W-1];
				res_seg_q <= SEG_W'(best_q);
			end
			OP_ZERO: begin
				res_x_q <= x1_q;
				res_y_q <= y1_q;
				res_status_q <= ST_ZERO;
			end
			OP_MDOTY: acc_q <= prod_sgn_x;
			OP_DOTSUM: acc_q <= acc_q + prod_sgn_y;
			OP_LENX: begin
				dot_neg_q <= acc_q[NUM_W-1];
				dot_mag_q <= acc_q[NUM_W-1] ? DOT_W'(NUM_W'(0) - acc_q) : acc_q[DOT_W-1:0];
			end
			OP_LENY: len2_q <= prod_q;
			OP_LENSUM: len2_q <= len2_q + prod_q;
			OP_NUM0: acc_q <= NUM_W'(len2_q >> 1);
			OP_NUM1: acc_q <= acc_q + prod_ext;
			OP_NUM2: acc_q <= acc_q + (prod_ext << MAG_W);
			OP_NUM3: acc_q <= acc_q + (prod_ext << (2 * MAG_W));
			OP_AXIS: begin
				if (axis_q) begin
					res_y_q <= r_sat;
					res_status_q <= ST_OK;
				end else begin
					res_x_q <= r_sat;
				end
				axis_q <= ~axis_q;
			end
			OP_OUT: begin
				proj_x_q <= res_x_q;
				proj_y_q <= res_y_q;
				seg_q <= res_seg_q;
				status_q <= res_status_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.is_query = is_query_q;
		stat.overflowed = overflowed_q;
		stat.short_line = vcount_q < CNTW'(2);
		stat.last_vertex = CNTW'(idx_q) + CNTW'(1) == vcount_q;
		stat.zero_seg = (emx_q == '0) && (emy_q == '0);
		stat.sqrt_done = sq_done;
		stat.div_done = dv_done;
		stat.axis_y = axis_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign proj_x = proj_x_q;
	assign proj_y = proj_y_q;
	assign segment_index = seg_q;
	assign status = status_q;

	`PPP_ASSERT(a_no_overwrite, clk, arst_n, (cmd.op == OP_OUT) |-> (!out_valid_q || out_ready), "pending result overwritten")
	`PPP_ASSERT(a_count_range, clk, arst_n, vcount_q <= CNTW'(MAX_VERTICES), "vertex count beyond store")
	`PPP_ASSERT(a_read_written, clk, arst_n, (cmd.op == OP_READ) |-> (CNTW'(idx_q) < vcount_q), "read of unwritten vertex")
	`PPP_ASSERT(a_valid_source, clk, arst_n, $rose(out_valid_q) |-> $past(cmd.op == OP_OUT), "result raised without write")
endmodule

/* rtl/core/ppp_ctrl.sv */
// Controller state machine sequencing loads, the segment scan and the projection
module ppp_ctrl import ppp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);
	ppp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_CAPTURE;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.is_query) begin
					cmd.op = OP_LOAD;
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_QSET;
					state_d = (stat.overflowed || stat.short_line) ? S_OUT : S_RD;
				end
			end
			S_RD: begin cmd.op = OP_READ; state_d = S_DIFF; end
			S_DIFF: begin cmd.op = OP_DIFF; state_d = S_SQX; end
			S_SQX: begin cmd.op = OP_SQX; state_d = S_SQY; end
			S_SQY: begin cmd.op = OP_SQY; state_d = S_SUMS; end
			S_SUMS: begin cmd.op = OP_SUMS; state_d = S_SQ_START; end
			S_SQ_START: begin cmd.op = OP_SQ_START; state_d = S_SQ_WAIT; end
			S_SQ_WAIT: begin
				if (stat.sqrt_done) state_d = S_SCORE;
			end
			S_SCORE: begin
				cmd.op = OP_SCORE;
				state_d = stat.last_vertex ? S_PSEL : S_RD;
			end
			S_PSEL: begin cmd.op = OP_PSEL; state_d = S_PRD1; end
			S_PRD1: begin cmd.op = OP_READ; state_d = S_PV1; end
			S_PV1: begin cmd.op = OP_PV1; state_d = S_PRD2; end
			S_PRD2: begin cmd.op = OP_READ; state_d = S_EDGE; end
			S_EDGE: begin cmd.op = OP_EDGE; state_d = S_ZCHK; end
			S_ZCHK: begin
				if (stat.zero_seg) begin
					cmd.op = OP_ZERO;
					state_d = S_OUT;
				end else begin
					state_d = S_M1;
				end
			end
			S_M1: begin cmd.op = OP_MDOTX; state_d = S_M2; end
			S_M2: begin cmd.op = OP_MDOTY; state_d = S_M3; end
			S_M3: begin cmd.op = OP_DOTSUM; state_d = S_M4; end
			S_M4: begin cmd.op = OP_LENX; state_d = S_M5; end
			S_M5: begin cmd.op = OP_LENY; state_d = S_M6; end
			S_M6: begin cmd.op = OP_LENSUM; state_d = S_A1; end
			S_A1: begin cmd.op = OP_NUM0; state_d = S_A2; end
			S_A2: begin cmd.op = OP_NUM1; state_d = S_A3; end
			S_A3: begin cmd.op = OP_NUM2; state_d = S_A4; end
			S_A4: begin cmd.op = OP_NUM3; state_d = S_DV_START; end
			S_DV_START: begin cmd.op = OP_DIV_START; state_d = S_DV_WAIT; end
			S_DV_WAIT: begin
				if (stat.div_done) state_d = S_AFIN;
			end
			S_AFIN: begin
				cmd.op = OP_AXIS;
				state_d = stat.axis_y ? S_OUT : S_A1;
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.op = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* rtl/core/polyline_point_projection_top.sv */
// Top level of the polyline point projection block
// Vertex load: the vertex is stored in the decide state after acceptance, then the controller returns to idle.
// Query on N vertices: a decode state, then a scan over every vertex (33-step square root each),
// then the projection (two 102-step divisions), and finally the result is written to the output.
// Short, overflowed or zero-length queries finish early; a result waits in the output register.
// Reset clears vertex count, line and overflow flags and the controller; vertex store is not cleared.
module polyline_point_projection_top import ppp_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      req_type,
	input  logic signed [COORD_W-1:0] coord_x,
	input  logic signed [COORD_W-1:0] coord_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [COORD_W-1:0] proj_x,
	output logic signed [COORD_W-1:0] proj_y,
	output logic [SEG_W-1:0]          segment_index,
	output logic [1:0]                status
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ppp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ppp_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.proj_x        (proj_x),
		.proj_y        (proj_y),
		.segment_index (segment_index),
		.status        (status)
	);
endmodule

/* sim/polyline_point_projection_top_tb.sv */
// Self-checking testbench for the polyline point projection block
`timescale 1ns / 1ps

module polyline_point_projection_top_tb;
	import ppp_pkg::*;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam int STORE_DEPTH = MAX_VERTICES_DEF;
	localparam int IDLE_LIMIT = 60000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [SEG_W-1:0] seg;
		logic [1:0] st;
	} projection_t;

	class projection_scoreboard;
		longint vert_x[STORE_DEPTH];
		longint vert_y[STORE_DEPTH];
		int vcount;
		bit closed;
		bit ovf;
		projection_t pending_q[$];
		int errors;

		function new();
			vcount = 0;
			closed = 0;
			ovf = 0;
			errors = 0;
		endfunction

		function automatic logic [63:0] floor_sqrt(logic [127:0] s);
			logic [127:0] r;
			logic [127:0] t;
			r = 0;
			for (int b = COORD_W + 1; b >= 0; b--) begin
				t = r | (128'd1 << b);
				if (s >= t * t) begin
					r = t;
				end
			end
			return r[63:0];
		endfunction

		function automatic logic [63:0] distance(longint ax, longint ay, longint px, longint py);
			logic [127:0] mx;
			logic [127:0] my;
			longint dx;
			longint dy;
			dx = ax - px;
			dy = ay - py;
			mx = 128'(dx < 0 ? -dx : dx);
			my = 128'(dy < 0 ? -dy : dy);
			return floor_sqrt(mx * mx + my * my);
		endfunction

		function automatic logic [COORD_W-1:0] project_axis(longint v1, longint e,
				logic [127:0] dot_mag, bit dot_neg, logic [127:0] len2);
			logic [127:0] em;
			logic [127:0] q;
			longint r;
			longint qm;
			em = 128'(e < 0 ? -e : e);
			q = (dot_mag * em + (len2 >> 1)) / len2;
			qm = (q > (128'd1 << 50)) ? (longint'(1) << 50) : longint'(q[63:0]);
			r = (dot_neg != (e < 0)) ? v1 - qm : v1 + qm;
			if (r > 64'sh7FFFFFFF) begin
				r = 64'sh7FFFFFFF;
			end else if (r < -64'sh80000000) begin
				r = -64'sh80000000;
			end
			return r[COORD_W-1:0];
		endfunction

		function void note_input(logic req, logic signed [COORD_W-1:0] cx,
				logic signed [COORD_W-1:0] cy);
			projection_t res;
			longint px;
			longint py;
			longint x1;
			longint y1;
			longint ex;
			longint ey;
			logic [63:0] d;
			logic [63:0] bestd;
			int best;
			logic signed [127:0] dot;
			logic signed [127:0] len2;
			bit neg;
			px = longint'(cx);
			py = longint'(cy);
			if (req == REQ_LOAD) begin
				if (closed) begin
					vcount = 0;
					ovf = 0;
					closed = 0;
				end
				if (vcount < STORE_DEPTH) begin
					vert_x[vcount] = px;
					vert_y[vcount] = py;
					vcount++;
				end else begin
					ovf = 1;
				end
				return;
			end
			closed = 1;
			res.px = 0;
			res.py = 0;
			res.seg = 0;
			if (ovf) begin
				res.st = ST_OVF;
			end else if (vcount < 2) begin
				res.st = ST_SHORT;
			end else begin
				best = 0;
				bestd = 0;
				for (int i = 0; i + 1 < vcount; i++) begin
					d = distance(vert_x[i], vert_y[i], px, py)
						+ distance(vert_x[i + 1], vert_y[i + 1], px, py);
					if (i == 0 || d < bestd) begin
						bestd = d;
						best = i;
					end
				end
				x1 = vert_x[best];
				y1 = vert_y[best];
				ex = vert_x[best + 1] - x1;
				ey = vert_y[best + 1] - y1;
				res.seg = best[SEG_W-1:0];
				if (ex == 0 && ey == 0) begin
					res.px = x1[COORD_W-1:0];
					res.py = y1[COORD_W-1:0];
					res.st = ST_ZERO;
				end else begin
					dot = 128'(signed'(ex)) * 128'(signed'(px - x1))
						+ 128'(signed'(ey)) * 128'(signed'(py - y1));
					neg = dot < 0;
					if (neg) begin
						dot = -dot;
					end
					len2 = 128'(signed'(ex)) * 128'(signed'(ex))
						+ 128'(signed'(ey)) * 128'(signed'(ey));
					res.px = project_axis(x1, ex, dot, neg, len2);
					res.py = project_axis(y1, ey, dot, neg, len2);
					res.st = ST_OK;
				end
			end
			pending_q = {pending_q, res};
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
			errors++;
		endtask

		task check(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
				logic [SEG_W-1:0] seg, logic [1:0] st);
			projection_t want;
			if (pending_q.size() == 0) begin
				report("result with none pending, status", 64'(st), 64'(0));
				return;
			end
			want = pending_q.pop_front();
			if (st !== want.st) begin
				report("status", 64'(st), 64'(want.st));
			end
			if (seg !== want.seg) begin
				report("segment_index", 64'(seg), 64'(want.seg));
			end
			if (px !== want.px) begin
				report("proj_x", 64'(px), 64'(want.px));
			end
			if (py !== want.py) begin
				report("proj_y", 64'(py), 64'(want.py));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic out_valid;
	logic out_ready;
	logic signed [COORD_W-1:0] proj_x;
	logic signed [COORD_W-1:0] proj_y;
	logic [SEG_W-1:0] segment_index;
	logic [1:0] status;

	projection_scoreboard sb;
	int idle_cycles;
	int burst_left;
	int stall_mode;
	int stall_left;

	polyline_point_projection_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.proj_x(proj_x),
		.proj_y(proj_y),
		.segment_index(segment_index),
		.status(status)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_input(req_type, coord_x, coord_y);
			end
			if (out_valid && out_ready) begin
				sb.check(proj_x, proj_y, segment_index, status);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// receiver: always ready, light stalls or heavy stalls, switched in stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3: return $urandom();
			4: return $urandom_range(0, 15) << 16;
			default: return COORD_W'(signed'($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	task send_item(logic req, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 8);
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= req;
		coord_x <= cx;
		coord_y <= cy;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
	endtask

	task random_line(int nverts, int nqueries);
		logic [COORD_W-1:0] bx;
		logic [COORD_W-1:0] by;
		bx = rand_coord();
		by = rand_coord();
		for (int i = 0; i < nverts; i++) begin
			case ($urandom_range(0, 7))
				0: send_item(REQ_LOAD, bx, by);
				1, 2: send_item(REQ_LOAD, rand_coord(), rand_coord());
				default: begin
					bx = bx + COORD_W'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
					by = by + COORD_W'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
					send_item(REQ_LOAD, bx, by);
				end
			endcase
		end
		for (int q = 0; q < nqueries; q++) begin
			if ($urandom_range(0, 2) == 0) begin
				send_item(REQ_QUERY, rand_coord(), rand_coord());
			end else begin
				send_item(REQ_QUERY, bx + COORD_W'($urandom_range(0, 1 << 21)),
					by - COORD_W'($urandom_range(0, 1 << 21)));
			end
		end
	endtask

	initial begin
		int sent;
		int nv;
		int nq;
		int r;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		coord_x = '0;
		coord_y = '0;
		out_ready = 1'b0;
		idle_cycles = 0;
		burst_left = 0;
		stall_mode = 0;
		stall_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short lines, then extremes and saturation
		send_item(REQ_QUERY, 32'h0, 32'h0);
		send_item(REQ_LOAD, 32'h7FFFFFFF, 32'h80000000);
		send_item(REQ_QUERY, 32'h80000000, 32'h7FFFFFFF);
		send_item(REQ_LOAD, 32'h80000000, 32'h80000000);
		send_item(REQ_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_item(REQ_QUERY, 32'h80000000, 32'h7FFFFFFF);
		send_item(REQ_QUERY, 32'h7FFFFFFF, 32'h80000000);
		send_item(REQ_LOAD, 32'h00010000, 32'h0);
		send_item(REQ_LOAD, 32'h00010001, 32'h0);
		send_item(REQ_QUERY, 32'h7FFFFFFF, 32'h7FFFFFFF);
		// zero-length segment and a tie between segments
		send_item(REQ_LOAD, 32'h00030000, 32'hFFFD0000);
		send_item(REQ_LOAD, 32'h00030000, 32'hFFFD0000);
		send_item(REQ_QUERY, 32'h0, 32'h0);
		send_item(REQ_LOAD, 32'h0, 32'h0);
		send_item(REQ_LOAD, 32'h00010000, 32'h0);
		send_item(REQ_LOAD, 32'h00020000, 32'h0);
		send_item(REQ_QUERY, 32'h00010000, 32'h00050000);
		send_item(REQ_QUERY, 32'hFFFF0000, 32'hAAAA5555);
		sent = 18;
		drain_results();

		// full store, then overflow
		for (int k = 0; k < 2; k++) begin
			for (int i = 0; i < STORE_DEPTH + k; i++) begin
				send_item(REQ_LOAD, rand_coord(), rand_coord());
			end
			send_item(REQ_QUERY, rand_coord(), rand_coord());
			send_item(REQ_QUERY, 32'h0, 32'h0);
			sent += STORE_DEPTH + k + 2;
		end
		drain_results();

		while (sent < 1950) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				nv = $urandom_range(0, 1);
			end else if (r < 7) begin
				nv = $urandom_range(30, STORE_DEPTH + 2);
			end else begin
				nv = $urandom_range(2, 8);
			end
			nq = $urandom_range(1, 3);
			random_line(nv, nq);
			sent += nv + nq;
			if ($urandom_range(0, 40) == 0) begin
				drain_results();
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ppp_pkg.sv
rtl/core/ppp_sqrt.sv
rtl/core/ppp_div.sv
rtl/core/ppp_dp.sv
rtl/core/ppp_ctrl.sv
rtl/core/polyline_point_projection_top.sv
sim/polyline_point_projection_top_tb.sv
